@@ hw/rtl/sactl_pkg.sv @@
// Package of the set-associative cache tag lookup unit.
// Holds sizes, register indexes and the sequencer state type.
// Used by every module of the block but sactl_ram; depends on nothing.
package sactl_pkg;

  localparam int unsigned MaxWays  = 8;
  localparam int unsigned MaxSets  = 256;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned FillW    = 3;
  localparam int unsigned SetsRegW = 9;
  localparam int unsigned WaysRegW = 4;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [SetsRegW-1:0] SetsReset = 9'd256;
  localparam logic [WaysRegW-1:0] WaysReset = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETS = 1'b0,
    CFG_WAYS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CMP
  } state_e;

endpackage

@@ hw/rtl/sactl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the tag rows and the valid rows; depends on nothing.
module sactl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sactl_div.sv @@
// Restoring divider that retires one quotient bit per cycle.
// Splits the address into tag (quotient) and set index (remainder).
// Depends on sactl_pkg.
module sactl_div #(
  parameter int unsigned DivW = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sactl_pkg::AddrW-1:0] dividend_i,
  input  logic [DivW-1:0]           divisor_i,
  output logic                      done_o,
  output logic [sactl_pkg::AddrW-1:0] quot_o,
  output logic [DivW-1:0]           rem_o
);
  import sactl_pkg::*;

  localparam int unsigned CntW = $clog2(AddrW);

  logic [AddrW-1:0] quot_q, quot_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  div_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DivW:0]    shifted;
  logic [DivW:0]    diff;
  logic             ge;

  assign shifted = {rem_q, quot_q[AddrW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      quot_d = {quot_q[AddrW-2:0], ge};
      rem_d  = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(AddrW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/sactl_way_sel.sv @@
// Way compare and fill selection over one set row.
// Finds a hit, else the lowest invalid way, else way 0 with eviction.
// Depends on sactl_pkg.
module sactl_way_sel #(
  parameter int unsigned Ways  = 8,
  parameter int unsigned WayIW = (Ways > 1) ? $clog2(Ways) : 1,
  parameter int unsigned WayCW = $clog2(Ways + 1)
) (
  input  logic [Ways*sactl_pkg::AddrW-1:0] tags_i,
  input  logic [Ways-1:0]                  valid_i,
  input  logic [sactl_pkg::AddrW-1:0]      tag_i,
  input  logic [WayCW-1:0]                 ways_i,
  output logic                             hit_o,
  output logic                             evict_o,
  output logic [WayIW-1:0]                 fill_o
);
  import sactl_pkg::*;

  logic [Ways-1:0] match;
  logic [Ways-1:0] free;
  logic [WayIW-1:0] first_free;

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      match[w] = (WayCW'(w) < ways_i) && valid_i[w] && (tags_i[w*AddrW +: AddrW] == tag_i);
      free[w]  = (WayCW'(w) < ways_i) && !valid_i[w];
    end
    first_free = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (free[w]) begin
        first_free = WayIW'(w);
      end
    end
  end

  assign hit_o   = |match;
  assign evict_o = !hit_o && !(|free);
  assign fill_o  = (hit_o || evict_o) ? '0 : first_free;

endmodule

@@ hw/rtl/set_assoc_cache_tag_lookup_unit.sv @@
// Top level of the set-associative cache tag lookup unit.
// Sequencer, configuration registers, valid and tag RAMs, divider, way select.
// Depends on sactl_pkg, sactl_ram, sactl_div and sactl_way_sel.
//
//   channel   ports                               handshake
//   config    cfg_we_i, cfg_idx_i, cfg_data_i     written when cfg_we_i is high
//   request   start, busy, address_i              taken when start && !busy
//   result    valid_o, hit_o, fill_way_o,         shown for one cycle on valid_o
//             evicted_o
//
// A request passes, from acceptance to the edge that takes its result, through the
// divider steps, the cycle on the divider's done flag, the tag/valid RAM read, the
// compare and write-back cycle that loads the output register, and the result cycle.
// busy drops in the cycle the result is shown, so the next request may be taken then.
// After reset a clearing pass writes zeros to the valid RAM, one set per cycle, over all
// MAX_SETS sets while busy is high. The receiver cannot stall; results are never held.
module set_assoc_cache_tag_lookup_unit #(
  parameter int unsigned MAX_WAYS = sactl_pkg::MaxWays,
  parameter int unsigned MAX_SETS = sactl_pkg::MaxSets
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sactl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sactl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [sactl_pkg::AddrW-1:0]    address_i,
  output logic                          valid_o,
  output logic                          hit_o,
  output logic [sactl_pkg::FillW-1:0]    fill_way_o,
  output logic                          evicted_o
);
  import sactl_pkg::*;

  localparam int unsigned DivW  = $clog2(MAX_SETS + 1);
  localparam int unsigned SetW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WayIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WayCW = $clog2(MAX_WAYS + 1);
  localparam int unsigned RowW  = MAX_WAYS * AddrW;

  state_e state_q, state_d;

  logic [SetsRegW-1:0] sets_q;
  logic [WaysRegW-1:0] ways_q;
  logic [SetW-1:0]     clr_q, clr_d;
  logic [31:0]         sets32, ways32;
  logic [DivW-1:0]     eff_sets;
  logic [WayCW-1:0]    eff_ways;

  logic                div_start, div_done;
  logic [AddrW-1:0]    tag;
  logic [DivW-1:0]     rem;
  logic [SetW-1:0]     set_idx;

  logic [RowW-1:0]     tag_row, tag_row_wr;
  logic [MAX_WAYS-1:0] valid_row, valid_row_wr;
  logic                tag_we, valid_we;
  logic [SetW-1:0]     valid_waddr;
  logic [MAX_WAYS-1:0] valid_wdata;

  logic                sel_hit, sel_evict;
  logic [WayIW-1:0]    sel_fill;
  logic [31:0]         fill32;

  logic                res_valid_q;
  logic                res_hit_q, res_evict_q;
  logic [FillW-1:0]    res_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sets_q <= SetsReset;
      ways_q <= WaysReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SETS: sets_q <= cfg_data_i[SetsRegW-1:0];
        CFG_WAYS: ways_q <= cfg_data_i[WaysRegW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    sets32 = 32'(sets_q);
    if (sets32 == 32'd0) sets32 = 32'd1;
    if (sets32 > 32'(MAX_SETS)) sets32 = 32'(MAX_SETS);
    ways32 = 32'(ways_q);
    if (ways32 == 32'd0) ways32 = 32'd1;
    if (ways32 > 32'(MAX_WAYS)) ways32 = 32'(MAX_WAYS);
  end

  assign eff_sets = sets32[DivW-1:0];
  assign eff_ways = ways32[WayCW-1:0];
  assign set_idx  = rem[SetW-1:0];

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == SetW'(MAX_SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: if (start) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_READ;
      ST_READ: state_d = ST_CMP;
      ST_CMP:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    div_start   = 1'b0;
    tag_we      = 1'b0;
    valid_we    = 1'b0;
    valid_waddr = set_idx;
    valid_wdata = valid_row_wr;
    unique case (state_q)
      ST_CLEAR: begin
        valid_we    = 1'b1;
        valid_waddr = clr_q;
        valid_wdata = '0;
      end
      ST_IDLE: begin
        busy      = 1'b0;
        div_start = start;
      end
      ST_CMP: begin
        tag_we   = !sel_hit;
        valid_we = !sel_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= (state_q == ST_CMP);
    end
  end

  assign fill32 = 32'(sel_fill);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      res_hit_q   <= sel_hit;
      res_evict_q <= sel_evict;
      res_fill_q  <= fill32[FillW-1:0];
    end
  end

  always_comb begin
    tag_row_wr   = tag_row;
    valid_row_wr = valid_row;
    tag_row_wr[sel_fill*AddrW +: AddrW] = tag;
    valid_row_wr[sel_fill] = 1'b1;
  end

  sactl_div #(
    .DivW(DivW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(address_i),
    .divisor_i (eff_sets),
    .done_o    (div_done),
    .quot_o    (tag),
    .rem_o     (rem)
  );

  sactl_ram #(
    .Width(RowW),
    .Depth(MAX_SETS),
    .AddrW(SetW)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(set_idx),
    .wdata_i(tag_row_wr),
    .raddr_i(set_idx),
    .rdata_o(tag_row)
  );

  sactl_ram #(
    .Width(MAX_WAYS),
    .Depth(MAX_SETS),
    .AddrW(SetW)
  ) u_valid_ram (
    .clk_i  (clk_i),
    .we_i   (valid_we),
    .waddr_i(valid_waddr),
    .wdata_i(valid_wdata),
    .raddr_i(set_idx),
    .rdata_o(valid_row)
  );

  sactl_way_sel #(
    .Ways (MAX_WAYS),
    .WayIW(WayIW),
    .WayCW(WayCW)
  ) u_way_sel (
    .tags_i (tag_row),
    .valid_i(valid_row),
    .tag_i  (tag),
    .ways_i (eff_ways),
    .hit_o  (sel_hit),
    .evict_o(sel_evict),
    .fill_o (sel_fill)
  );

  assign valid_o    = res_valid_q;
  assign hit_o      = res_hit_q;
  assign fill_way_o = res_fill_q;
  assign evicted_o  = res_evict_q;

endmodule
